@@ rtl/stpc_pkg.sv @@
package stpc_pkg;

   // pixel component width
   localparam int COMP_W = 8;

   // red/blue correction: numerator (r-b)*48, reciprocal of (256-margin) in Q22
   localparam int NUM_W       = 14;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_W     = 23;
   localparam int QUOT_W      = 14;
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1 << (RECIP_SHIFT - 8));
   localparam logic [COMP_W-1:0] CORR_MIN = 8'd32;
   localparam logic [COMP_W-1:0] AMT_MAX  = 8'd255;

   // chroma arithmetic widths
   localparam int MUL_W = 24;
   localparam int SUM_W = 25;
   localparam logic [SUM_W-1:0] HALF_SHIFTED = SUM_W'(128 * 65536);

   // Q16 coefficients
   localparam logic [15:0] K_Y_R  = 16'd19595;
   localparam logic [15:0] K_Y_G  = 16'd38470;
   localparam logic [15:0] K_Y_B  = 16'd7471;
   localparam logic [15:0] K_CB_R = 16'd9699;
   localparam logic [15:0] K_CB_G = 16'd19071;
   localparam logic [15:0] K_HI   = 16'd28770;
   localparam logic [15:0] K_CR_G = 16'd24117;
   localparam logic [15:0] K_CR_B = 16'd4653;

   // threshold set codes
   localparam logic [1:0] MODE_TIGHT  = 2'd0;
   localparam logic [1:0] MODE_MEDIUM = 2'd1;
   localparam logic [1:0] MODE_WIDE   = 2'd2;
   localparam logic [1:0] MODE_LUMA   = 2'd3;

   // register indexes
   localparam logic REG_MARGIN = 1'b0;
   localparam logic REG_MODE   = 1'b1;

   // chroma windows
   localparam logic [7:0] T_CB_LO = 8'd85;
   localparam logic [7:0] T_CB_HI = 8'd127;
   localparam logic [7:0] T_CR_LO = 8'd135;
   localparam logic [7:0] T_CR_HI = 8'd173;
   localparam logic [7:0] M_CB_LO = 8'd77;
   localparam logic [7:0] M_CB_HI = 8'd135;
   localparam logic [7:0] M_CR_LO = 8'd133;
   localparam logic [7:0] M_CR_HI = 8'd180;
   localparam logic [7:0] W_CB_LO = 8'd69;
   localparam logic [7:0] W_CB_HI = 8'd142;
   localparam logic [7:0] W_CR_LO = 8'd131;
   localparam logic [7:0] W_CR_HI = 8'd187;
   localparam logic [7:0] L_CB_LO = 8'd77;
   localparam logic [7:0] L_CB_HI = 8'd127;
   localparam logic [7:0] L_CR_LO = 8'd133;
   localparam logic [7:0] L_CR_HI = 8'd173;

   // mask codes
   localparam logic [7:0] MASK_SKIN  = 8'd0;
   localparam logic [7:0] MASK_OTHER = 8'd255;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic              eob;
   } pix_type;

   typedef struct packed {
      logic               corr_en;
      logic [RECIP_W-1:0] recip;
      logic [1:0]         mode;
   } cfg_type;

endpackage

@@ rtl/skin_tone_pixel_classifier.sv @@
// Skin-tone pixel classifier.
// The req channel takes one RGB pixel per request (tdata: red, green, blue from
// bit 0 up; tlast marks the last pixel of a buffer). The rsp channel returns one
// mask byte per pixel: 0 for skin, 255 otherwise, with tlast copied through.
// An APB-style port holds two registers: correction_margin at 0x0 and
// skin_mode at 0x4. Write them only while no pixel is in flight.
// The pipeline has six stages: three of red/blue correction (numerator,
// reciprocal multiply, saturate and adjust) and three of chroma (constant
// products, Q16 sums, window test). One pixel is accepted every clock while
// the receiver does not stall; each stage holds one level of multiplies or a
// short add and compare.
// The correction divide by (256 - margin) uses a reciprocal looked up when the
// margin is written, so no divider sits in the pixel path.
// Reset clears both registers and empties the pipeline. When the receiver
// stalls, the result is held in the output register and each stage fills until
// its successor is full; only then is req_tready dropped. Nothing is lost or
// repeated across a stall.
module skin_tone_pixel_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // skin_mask [7:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import stpc_pkg::*;

   cfg_type cfg;
   pix_type req_pix, mid_pix;
   logic    mid_valid, mid_ready;

   // unpack the request
   assign req_pix.red   = req_tdata[7:0];
   assign req_pix.green = req_tdata[15:8];
   assign req_pix.blue  = req_tdata[23:16];
   assign req_pix.eob   = req_tlast;

   stpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   stpc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pix    (req_pix),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_pix   (mid_pix)
   );

   stpc_chroma u_chroma (
      .clock     (clock),
      .reset     (reset),
      .mode      (cfg.mode),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_pix    (mid_pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mask  (rsp_tdata),
      .out_eob   (rsp_tlast)
   );

   // an empty output stage lets the whole pipeline accept
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("request refused while output stage empty");

   // mask only ever carries the two codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == MASK_SKIN || rsp_tdata == MASK_OTHER))
      else $error("mask code out of range");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a request reaches the output only after passing every stage
   assert property (@(posedge clock) disable iff (reset)
      $past(!rsp_tvalid) && rsp_tvalid |-> !$past(reset, 5))
      else $error("result appeared without passing every stage");

endmodule

@@ rtl/stpc_csr.sv @@
module stpc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output stpc_pkg::cfg_type cfg
);
   import stpc_pkg::*;

   logic [RECIP_W-1:0] recip_tab [256];
   logic [7:0]         margin_ff;
   logic [1:0]         mode_ff;
   logic [RECIP_W-1:0] recip_ff;
   logic               wr;

   // reciprocal table: entry m holds ceil(2^22 / (256 - m))
   for (genvar i = 0; i < 256; i++) begin : g_recip
      localparam int unsigned Div   = 256 - i;
      localparam int unsigned RECIP = ((32'd1 << RECIP_SHIFT) + Div - 1) / Div;
      assign recip_tab[i] = RECIP_W'(RECIP);
   end

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   // register writes, reciprocal fetched with the margin
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
         mode_ff   <= MODE_TIGHT;
         recip_ff  <= RECIP_RESET;
      end else if (wr) begin
         unique case (paddr[2])
            REG_MARGIN: begin
               margin_ff <= pwdata[7:0];
               recip_ff  <= recip_tab[pwdata[7:0]];
            end
            REG_MODE: begin
               mode_ff <= pwdata[1:0];
            end
            default: begin
               mode_ff <= mode_ff;
            end
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (paddr[2])
         REG_MARGIN: prdata = {24'b0, margin_ff};
         REG_MODE:   prdata = {30'b0, mode_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg.corr_en = (margin_ff >= CORR_MIN);
   assign cfg.recip   = recip_ff;
   assign cfg.mode    = mode_ff;

endmodule

@@ rtl/stpc_corr.sv @@
module stpc_corr (
   input  logic              clock,
   input  logic              reset,
   input  stpc_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  stpc_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output stpc_pkg::pix_type out_pix
);
   import stpc_pkg::*;

   logic              en1, en2, en3;
   logic              v1_ff, v2_ff, v3_ff;
   pix_type           pix1_ff, pix2_ff, pix3_ff, pix3_in;
   logic              corr1_ff, corr1_in, corr2_ff;
   logic [NUM_W-1:0]  num1_ff, num1_in;
   logic [7:0]        diff;
   logic [PROD_W-1:0] prod2;
   logic [QUOT_W-1:0] quot2_ff, quot2_in;
   logic [7:0]        amt;

   // stage enables, each stage moves when its successor has room
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: correction decision and numerator (r-b)*48
   always_comb begin
      diff     = in_pix.red - in_pix.blue;
      corr1_in = cfg.corr_en && (in_pix.red > in_pix.blue);
      num1_in  = (NUM_W'(diff) << 5) + (NUM_W'(diff) << 4);
   end

   // stage 2: quotient through the reciprocal, exact for 14-bit numerators
   assign prod2    = PROD_W'(num1_ff) * PROD_W'(cfg.recip);
   assign quot2_in = prod2[RECIP_SHIFT +: QUOT_W];

   // stage 3: saturate amount and pull red toward blue
   always_comb begin
      if (!corr2_ff) begin
         amt = '0;
      end else if (quot2_ff > QUOT_W'(AMT_MAX)) begin
         amt = AMT_MAX;
      end else begin
         amt = quot2_ff[7:0];
      end
      pix3_in      = pix2_ff;
      pix3_in.red  = pix2_ff.red - amt;
      pix3_in.blue = pix2_ff.blue + amt;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en1) begin
         pix1_ff  <= in_pix;
         corr1_ff <= corr1_in;
         num1_ff  <= num1_in;
      end
      if (en2) begin
         pix2_ff  <= pix1_ff;
         corr2_ff <= corr1_ff;
         quot2_ff <= quot2_in;
      end
      if (en3) begin
         pix3_ff <= pix3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_pix   = pix3_ff;

endmodule

@@ rtl/stpc_chroma.sv @@
module stpc_chroma (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        mode,
   input  logic              in_valid,
   output logic              in_ready,
   input  stpc_pkg::pix_type in_pix,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_mask,
   output logic              out_eob
);
   import stpc_pkg::*;

   logic             en4, en5, en6;
   logic             v4_ff, v5_ff, v6_ff;
   // stage 4 products
   logic [MUL_W-1:0] yr_ff, yg_ff, yb_ff, cbr_ff, cbg_ff, cbb_ff, crr_ff, crg_ff, crb_ff;
   logic [7:0]       red4_ff, blue4_ff, red5_ff, blue5_ff;
   logic             eob4_ff, eob5_ff, eob6_ff;
   // stage 5 sums
   logic [SUM_W-1:0] scb5_in, scr5_in, luma5_in, luma5_ff;
   logic [7:0]       cb5_ff, cr5_ff;
   // stage 6 classification
   logic [SUM_W-1:0] mag;
   logic [7:0]       yq, yl, cb_l, cr_l, cb, cr;
   logic [7:0]       cb_lo, cb_hi, cr_lo, cr_hi;
   logic             skin;
   logic [7:0]       mask6_ff, mask6_in;

   assign en6      = !v6_ff || out_ready;
   assign en5      = !v5_ff || en6;
   assign en4      = !v4_ff || en5;
   assign in_ready = en4;

   // stage 5: Q16 sums with the 128 offset
   always_comb begin
      scb5_in  = SUM_W'(cbb_ff) + HALF_SHIFTED - SUM_W'(cbr_ff) - SUM_W'(cbg_ff);
      scr5_in  = SUM_W'(crr_ff) + HALF_SHIFTED - SUM_W'(crg_ff) - SUM_W'(crb_ff);
      luma5_in = SUM_W'(yr_ff) + SUM_W'(yg_ff) + SUM_W'(yb_ff) - HALF_SHIFTED;
   end

   // stage 6: luma truncated toward zero, then window test
   always_comb begin
      mag  = luma5_ff[SUM_W-1] ? (SUM_W'(0) - luma5_ff) : luma5_ff;
      yq   = mag[23:16];
      yl   = luma5_ff[SUM_W-1] ? (8'd0 - yq) : yq;
      cr_l = red5_ff - yl;
      cb_l = blue5_ff - yl;
      cb   = cb5_ff;
      cr   = cr5_ff;
      unique case (mode)
         MODE_TIGHT: begin
            cb_lo = T_CB_LO; cb_hi = T_CB_HI; cr_lo = T_CR_LO; cr_hi = T_CR_HI;
         end
         MODE_MEDIUM: begin
            cb_lo = M_CB_LO; cb_hi = M_CB_HI; cr_lo = M_CR_LO; cr_hi = M_CR_HI;
         end
         MODE_WIDE: begin
            cb_lo = W_CB_LO; cb_hi = W_CB_HI; cr_lo = W_CR_LO; cr_hi = W_CR_HI;
         end
         MODE_LUMA: begin
            cb_lo = L_CB_LO; cb_hi = L_CB_HI; cr_lo = L_CR_LO; cr_hi = L_CR_HI;
            cb    = cb_l;
            cr    = cr_l;
         end
         default: begin
            cb_lo = T_CB_LO; cb_hi = T_CB_HI; cr_lo = T_CR_LO; cr_hi = T_CR_HI;
         end
      endcase
      skin     = (cb >= cb_lo) && (cb <= cb_hi) && (cr >= cr_lo) && (cr <= cr_hi);
      mask6_in = skin ? MASK_SKIN : MASK_OTHER;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (en4) begin
         yr_ff    <= MUL_W'(in_pix.red)   * MUL_W'(K_Y_R);
         yg_ff    <= MUL_W'(in_pix.green) * MUL_W'(K_Y_G);
         yb_ff    <= MUL_W'(in_pix.blue)  * MUL_W'(K_Y_B);
         cbr_ff   <= MUL_W'(in_pix.red)   * MUL_W'(K_CB_R);
         cbg_ff   <= MUL_W'(in_pix.green) * MUL_W'(K_CB_G);
         cbb_ff   <= MUL_W'(in_pix.blue)  * MUL_W'(K_HI);
         crr_ff   <= MUL_W'(in_pix.red)   * MUL_W'(K_HI);
         crg_ff   <= MUL_W'(in_pix.green) * MUL_W'(K_CR_G);
         crb_ff   <= MUL_W'(in_pix.blue)  * MUL_W'(K_CR_B);
         red4_ff  <= in_pix.red;
         blue4_ff <= in_pix.blue;
         eob4_ff  <= in_pix.eob;
      end
      if (en5) begin
         cb5_ff   <= scb5_in[23:16];
         cr5_ff   <= scr5_in[23:16];
         luma5_ff <= luma5_in;
         red5_ff  <= red4_ff;
         blue5_ff <= blue4_ff;
         eob5_ff  <= eob4_ff;
      end
      if (en6) begin
         mask6_ff <= mask6_in;
         eob6_ff  <= eob5_ff;
      end
   end

   assign out_valid = v6_ff;
   assign out_mask  = mask6_ff;
   assign out_eob   = eob6_ff;

endmodule
